FILE: design/interval_room_assigner_defines.svh
// Assertion helpers for the interval room assigner
`ifndef INTERVAL_ROOM_ASSIGNER_DEFINES_SVH
`define INTERVAL_ROOM_ASSIGNER_DEFINES_SVH
`define IRA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("violated: label");
`define IRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("violated: label");
`endif

FILE: design/ira_pkg.sv
`default_nettype none
package ira_pkg;
   localparam int TimeWidth = 31;
   localparam int RoomWidth = 6;
   localparam int IndexWidth = 5;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PICK,
      ST_ROOM,
      ST_DECIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic close;
      logic pick_step;
      logic room_init;
      logic room_step;
      logic decide;
      logic emit_step;
   } cmd_type;

   typedef struct packed {
      logic batch_done;
      logic pick_done;
      logic room_done;
      logic last_pick;
      logic emit_done;
   } status_type;
endpackage
`default_nettype wire

FILE: design/ira_datapath.sv
`default_nettype none
module ira_datapath import ira_pkg::*; #(
   parameter int MAX_ITEMS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output status_type                 status,
   input  wire logic [TimeWidth-1:0]  req_start_time,
   input  wire logic [TimeWidth-1:0]  req_end_time,
   input  wire logic                  req_is_last,
   output logic                       rsp_valid,
   output logic [IndexWidth-1:0]      rsp_item_index,
   output logic [RoomWidth-1:0]       rsp_room,
   output logic [RoomWidth-1:0]       rsp_room_total,
   output logic                       rsp_last_result
);
   localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CBITS = $clog2(MAX_ITEMS + 1);
   localparam int CW = (CBITS > RoomWidth) ? CBITS : RoomWidth;

   logic [TimeWidth-1:0] starts_mem [MAX_ITEMS];
   logic [TimeWidth-1:0] ends_mem   [MAX_ITEMS];
   logic [TimeWidth-1:0] free_mem   [MAX_ITEMS];
   logic [RoomWidth-1:0] room_mem   [MAX_ITEMS];

   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         rooms_ff, rooms_in;
   logic [CW-1:0]         k_ff, k_in;
   logic [CW-1:0]         x_ff, x_in;
   logic [CW-1:0]         r_ff, r_in;
   logic                  first_ff, first_in;
   logic                  found_ff, found_in;
   logic [TimeWidth-1:0]  sel_start_ff, sel_start_in;
   logic [AW-1:0]         sel_idx_ff, sel_idx_in;
   logic [TimeWidth-1:0]  last_start_ff, last_start_in;
   logic [AW-1:0]         last_idx_ff, last_idx_in;
   logic [TimeWidth-1:0]  best_t_ff, best_t_in;
   logic [CW-1:0]         best_r_ff, best_r_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IndexWidth-1:0] rsp_index_ff, rsp_index_in;
   logic [RoomWidth-1:0]  rsp_room_ff, rsp_room_in;
   logic [RoomWidth-1:0]  rsp_total_ff, rsp_total_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [TimeWidth-1:0]  starts_rd_ff;
   logic [TimeWidth-1:0]  ends_rd_ff;
   logic [TimeWidth-1:0]  free_rd_ff;
   logic [RoomWidth-1:0]  room_rd_ff;

   logic [CW-1:0] x_prev;
   logic          eligible;
   logic          reuse;
   logic [CW-1:0] free_wa;
   logic [CW-1:0] room_num;

   // read data is registered behind the address, so compare entry x-1
   assign x_prev = x_ff - CW'(1);
   // next in start order: strictly after the last pick by (start, index)
   assign eligible = first_ff || (starts_rd_ff > last_start_ff) ||
                     ((starts_rd_ff == last_start_ff) && (x_prev[AW-1:0] > last_idx_ff));
   assign reuse = (rooms_ff != '0) && (best_t_ff <= sel_start_ff);
   assign free_wa = reuse ? best_r_ff : rooms_ff;
   assign room_num = free_wa + CW'(1);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         starts_mem[count_ff[AW-1:0]] <= req_start_time;
         ends_mem[count_ff[AW-1:0]]   <= req_end_time;
      end
      starts_rd_ff <= starts_mem[x_ff[AW-1:0]];
      ends_rd_ff <= ends_mem[sel_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         free_mem[free_wa[AW-1:0]] <= ends_rd_ff;
         room_mem[sel_idx_ff] <= room_num[RoomWidth-1:0];
      end
      free_rd_ff <= free_mem[r_ff[AW-1:0]];
      room_rd_ff <= room_mem[x_ff[AW-1:0]];
   end

   always_comb begin
      count_in = count_ff;
      rooms_in = rooms_ff;
      k_in = k_ff;
      x_in = x_ff;
      r_in = r_ff;
      first_in = first_ff;
      found_in = found_ff;
      sel_start_in = sel_start_ff;
      sel_idx_in = sel_idx_ff;
      last_start_in = last_start_ff;
      last_idx_in = last_idx_ff;
      best_t_in = best_t_ff;
      best_r_in = best_r_ff;
      rsp_valid_in = 1'b0;
      rsp_index_in = rsp_index_ff;
      rsp_room_in = rsp_room_ff;
      rsp_total_in = rsp_total_ff;
      rsp_last_in = rsp_last_ff;
      if (cmd.load) count_in = count_ff + CW'(1);
      if (cmd.close) begin
         k_in = '0;
         rooms_in = '0;
         x_in = '0;
         first_in = 1'b1;
         found_in = 1'b0;
      end
      if (cmd.pick_step) begin
         if (x_ff != '0 && eligible && (!found_ff || starts_rd_ff < sel_start_ff)) begin
            found_in = 1'b1;
            sel_start_in = starts_rd_ff;
            sel_idx_in = x_prev[AW-1:0];
         end
         x_in = x_ff + CW'(1);
      end
      if (cmd.room_init) r_in = '0;
      if (cmd.room_step) begin
         // strict compare keeps the lowest room on equal ends
         if (r_ff != '0 && (r_ff == CW'(1) || free_rd_ff < best_t_ff)) begin
            best_t_in = free_rd_ff;
            best_r_in = r_ff - CW'(1);
         end
         r_in = r_ff + CW'(1);
      end
      if (cmd.decide) begin
         if (!reuse) rooms_in = rooms_ff + CW'(1);
         first_in = 1'b0;
         found_in = 1'b0;
         last_start_in = sel_start_ff;
         last_idx_in = sel_idx_ff;
         k_in = k_ff + CW'(1);
         x_in = '0;
      end
      if (cmd.emit_step) begin
         if (x_ff != '0) begin
            rsp_valid_in = 1'b1;
            rsp_index_in = x_prev[IndexWidth-1:0];
            rsp_room_in = room_rd_ff;
            rsp_total_in = rooms_ff[RoomWidth-1:0];
            rsp_last_in = (x_ff == count_ff);
         end
         x_in = x_ff + CW'(1);
         if (x_ff == count_ff) count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rooms_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rooms_ff <= rooms_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff <= k_in;
      x_ff <= x_in;
      r_ff <= r_in;
      first_ff <= first_in;
      found_ff <= found_in;
      sel_start_ff <= sel_start_in;
      sel_idx_ff <= sel_idx_in;
      last_start_ff <= last_start_in;
      last_idx_ff <= last_idx_in;
      best_t_ff <= best_t_in;
      best_r_ff <= best_r_in;
      rsp_index_ff <= rsp_index_in;
      rsp_room_ff <= rsp_room_in;
      rsp_total_ff <= rsp_total_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item_index = rsp_index_ff;
   assign rsp_room = rsp_room_ff;
   assign rsp_room_total = rsp_total_ff;
   assign rsp_last_result = rsp_last_ff;

   always_comb begin
      status.batch_done = req_is_last || (count_ff + CW'(1) == CW'(MAX_ITEMS));
      status.pick_done = (x_ff == count_ff);
      status.room_done = (r_ff == rooms_ff);
      status.last_pick = (k_ff + CW'(1) == count_ff);
      status.emit_done = (x_ff == count_ff);
   end
endmodule
`default_nettype wire

FILE: design/ira_controller.sv
`default_nettype none
module ira_controller import ira_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire status_type status,
   output cmd_type         cmd
);
   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD:
            if (start && status.batch_done) state_in = ST_PICK;
         ST_PICK:
            if (status.pick_done) state_in = ST_ROOM;
         ST_ROOM:
            if (status.room_done) state_in = ST_DECIDE;
         ST_DECIDE:
            if (status.last_pick) state_in = ST_EMIT;
            else state_in = ST_PICK;
         ST_EMIT:
            if (status.emit_done) state_in = ST_LOAD;
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      cmd = '0;
      busy = (state_ff != ST_LOAD);
      unique case (state_ff)
         ST_LOAD: begin
            cmd.load = start;
            cmd.close = start && status.batch_done;
         end
         ST_PICK: begin
            cmd.pick_step = 1'b1;
            cmd.room_init = status.pick_done;
         end
         ST_ROOM: cmd.room_step = 1'b1;
         ST_DECIDE: cmd.decide = 1'b1;
         ST_EMIT: cmd.emit_step = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

FILE: design/interval_room_assigner.sv
// channel | ports                                   | handshake
// input   | req_start_time req_end_time req_is_last | start & !busy
// result  | rsp_item_index rsp_room rsp_room_total  | rsp_valid, one cycle
//         | rsp_last_result                         |
// Loading stores one item per start while idle; the closing item (last flag or full store) raises busy.
// For each interval the block scans the stored starts for the next one in start order,
// scans the open rooms for the earliest free one, then reuses it if free or opens a new room.
// Results then leave back to back, the last one as busy drops.
// Sync reset clears item and room counts, returns to loading; the receiver cannot stall.
`default_nettype none
module interval_room_assigner import ira_pkg::*; #(
   parameter int MAX_ITEMS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [TimeWidth-1:0]  req_start_time,
   input  wire logic [TimeWidth-1:0]  req_end_time,
   input  wire logic                  req_is_last,
   output logic                       rsp_valid,
   output logic [IndexWidth-1:0]      rsp_item_index,
   output logic [RoomWidth-1:0]       rsp_room,
   output logic [RoomWidth-1:0]       rsp_room_total,
   output logic                       rsp_last_result
);
   cmd_type    cmd;
   status_type status;

   ira_controller u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .status(status), .cmd(cmd)
   );

   ira_datapath #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_start_time(req_start_time), .req_end_time(req_end_time),
      .req_is_last(req_is_last), .rsp_valid(rsp_valid),
      .rsp_item_index(rsp_item_index), .rsp_room(rsp_room),
      .rsp_room_total(rsp_room_total), .rsp_last_result(rsp_last_result)
   );
endmodule
`default_nettype wire

FILE: design/ira_checker.sv
`default_nettype none
`include "interval_room_assigner_defines.svh"
module ira_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       busy,
   input wire logic       rsp_valid,
   input wire logic [5:0] rsp_room,
   input wire logic [5:0] rsp_room_total,
   input wire logic       rsp_last_result
);
   `IRA_ASSERT_IMPL(a_room_in_range, clock, reset, rsp_valid, rsp_room != 6'd0 && rsp_room <= rsp_room_total)
   `IRA_ASSERT_IMPL(a_rsp_while_busy, clock, reset, rsp_valid, busy || rsp_last_result)
   `IRA_ASSERT_NEXT(a_last_frees, clock, reset, rsp_valid && rsp_last_result, !rsp_valid)
endmodule
bind interval_room_assigner ira_checker u_ira_checker (
   .clock(clock), .reset(reset), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_room(rsp_room),
   .rsp_room_total(rsp_room_total), .rsp_last_result(rsp_last_result)
);
`default_nettype wire
